// File: design/cbq_pkg.sv
// Package for the cascaded biquad filter: fixed widths, register indexes,
// tap codes and the controller/datapath command and status structs.
// No dependencies.
package cbq_pkg;

  localparam int COEF_W          = 24;
  localparam int STATE_W         = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 24;
  localparam int STAGES_W        = 2;
  localparam int SAMPLE_W_DEF    = 24;
  localparam int COEF_FRAC_DEF   = 21;
  localparam int TAP_COUNT       = 5;
  localparam int STEP_W          = 3;

  localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STAGES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HP     = 3'd5;

  localparam logic [STAGES_W-1:0] STAGES_TWO = 2'd2;

  typedef enum logic [2:0] {
    TAP_X0 = 3'd0,
    TAP_X1 = 3'd1,
    TAP_X2 = 3'd2,
    TAP_Y1 = 3'd3,
    TAP_Y2 = 3'd4
  } tap_t;

  typedef struct packed {
    logic load_x;
    logic mul_en;
    tap_t tap;
    logic sec;
    logic acc_clr;
    logic acc_add;
    logic upd;
    logic out_load;
  } cbq_cmd_t;

  typedef struct packed {
    logic two_stage;
  } cbq_sts_t;

endpackage

// File: design/cbq_datapath.sv
// Datapath of the cascaded biquad filter: configuration registers, section
// history, one shared multiplier, accumulator and output saturation.
// Depends on cbq_pkg.
module cbq_datapath #(
  parameter int SAMPLE_WIDTH   = cbq_pkg::SAMPLE_W_DEF,
  parameter int COEF_FRAC_BITS = cbq_pkg::COEF_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbq_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
  input  cbq_pkg::cbq_cmd_t                   cmd,
  output cbq_pkg::cbq_sts_t                   sts,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);

  localparam int SW     = cbq_pkg::STATE_W;
  localparam int CW     = cbq_pkg::COEF_W;
  localparam int PROD_W = SW + CW;
  localparam int ACC_W  = SW + CW - COEF_FRAC_BITS + 3;
  localparam int DIFF_W = SW + 2;

  localparam logic signed [DIFF_W-1:0] OUT_MAX =
    {{(DIFF_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [DIFF_W-1:0] OUT_MIN =
    {{(DIFF_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [CW-1:0]           b0_r, b1_r, a1_r, a2_r;
  logic [cbq_pkg::STAGES_W-1:0]   stages_r;
  logic                           hp_r;

  logic signed [SAMPLE_WIDTH-1:0] x_r, fid1_r, fid2_r;
  logic signed [SW-1:0]           fod1_r, fod2_r, sid1_r, sid2_r, sod1_r, sod2_r;
  logic signed [SW-1:0]           lp_r;
  logic signed [PROD_W-1:0]       prod_r;
  cbq_pkg::tap_t                  tap_d_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [SAMPLE_WIDTH-1:0] out_r;

  logic signed [CW-1:0]     coef_sel;
  logic signed [SW-1:0]     op_sel;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]  term;
  logic signed [SW-1:0]     y_new;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SAMPLE_WIDTH-1:0] out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r     <= '0;
      b1_r     <= '0;
      a1_r     <= '0;
      a2_r     <= '0;
      stages_r <= cbq_pkg::STAGES_W'(1);
      hp_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        cbq_pkg::REG_B0:     b0_r     <= cfg_data;
        cbq_pkg::REG_B1:     b1_r     <= cfg_data;
        cbq_pkg::REG_A1:     a1_r     <= cfg_data;
        cbq_pkg::REG_A2:     a2_r     <= cfg_data;
        cbq_pkg::REG_STAGES: stages_r <= cfg_data[cbq_pkg::STAGES_W-1:0];
        cbq_pkg::REG_HP:     hp_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign sts.two_stage = (stages_r == cbq_pkg::STAGES_TWO);

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.tap)
      cbq_pkg::TAP_X0: begin
        coef_sel = b0_r;
        op_sel   = cmd.sec ? lp_r : SW'(x_r);
      end
      cbq_pkg::TAP_X1: begin
        coef_sel = b1_r;
        op_sel   = cmd.sec ? sid1_r : SW'(fid1_r);
      end
      cbq_pkg::TAP_X2: begin
        coef_sel = b0_r;
        op_sel   = cmd.sec ? sid2_r : SW'(fid2_r);
      end
      cbq_pkg::TAP_Y1: begin
        coef_sel = a1_r;
        op_sel   = cmd.sec ? sod1_r : fod1_r;
      end
      cbq_pkg::TAP_Y2: begin
        coef_sel = a2_r;
        op_sel   = cmd.sec ? sod2_r : fod2_r;
      end
      default: begin
        coef_sel = '0;
        op_sel   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r  <= PROD_W'(coef_sel) * PROD_W'(op_sel);
      tap_d_r <= cmd.tap;
    end
  end

  // floor shift, then narrowed to the accumulator width
  assign prod_sh = prod_r >>> COEF_FRAC_BITS;
  assign term    = ACC_W'(prod_sh);

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      if (tap_d_r == cbq_pkg::TAP_Y1 || tap_d_r == cbq_pkg::TAP_Y2) begin
        acc_r <= acc_r - term;
      end else begin
        acc_r <= acc_r + term;
      end
    end
  end

  always_comb begin
    if (acc_r > ACC_W'(signed'({1'b0, {(SW-1){1'b1}}}))) begin
      y_new = {1'b0, {(SW-1){1'b1}}};
    end else if (acc_r < ACC_W'(signed'({1'b1, {(SW-1){1'b0}}}))) begin
      y_new = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y_new = acc_r[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fid1_r <= '0;
      fid2_r <= '0;
      fod1_r <= '0;
      fod2_r <= '0;
      sid1_r <= '0;
      sid2_r <= '0;
      sod1_r <= '0;
      sod2_r <= '0;
    end else if (cmd.upd) begin
      if (cmd.sec) begin
        sid2_r <= sid1_r;
        sid1_r <= lp_r;
        sod2_r <= sod1_r;
        sod1_r <= y_new;
      end else begin
        fid2_r <= fid1_r;
        fid1_r <= x_r;
        fod2_r <= fod1_r;
        fod1_r <= y_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x_r <= sample_in;
    end
    if (cmd.upd) begin
      lp_r <= y_new;
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    if (hp_r) begin
      diff = DIFF_W'(x_r) - DIFF_W'(lp_r);
    end else begin
      diff = DIFF_W'(lp_r);
    end
    if (diff > OUT_MAX) begin
      out_nxt = OUT_MAX[SAMPLE_WIDTH-1:0];
    end else if (diff < OUT_MIN) begin
      out_nxt = OUT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      out_nxt = diff[SAMPLE_WIDTH-1:0];
    end
  end

  assign sample_out = out_r;

endmodule

// File: design/cbq_ctrl.sv
// Controller of the cascaded biquad filter: sequences the five taps of each
// section through the shared multiplier and owns both handshakes.
// Depends on cbq_pkg.
module cbq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  cbq_pkg::cbq_sts_t sts,
  output cbq_pkg::cbq_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_UPD,
    ST_DONE
  } state_t;

  localparam logic [cbq_pkg::STEP_W-1:0] STEP_LAST = cbq_pkg::STEP_W'(cbq_pkg::TAP_COUNT);

  state_t                       state_r, state_nxt;
  logic [cbq_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                         sec_r, sec_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         in_acc, out_acc, out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    sec_nxt       = sec_r;
    out_valid_nxt = out_valid_r && !out_acc;
    cmd           = '0;
    cmd.sec       = sec_r;
    cmd.tap       = cbq_pkg::tap_t'(step_r);
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.load_x = 1'b1;
          state_nxt  = ST_MAC;
          step_nxt   = '0;
          sec_nxt    = 1'b0;
        end
      end
      ST_MAC: begin
        cmd.mul_en  = (step_r != STEP_LAST);
        cmd.acc_clr = (step_r == '0);
        cmd.acc_add = (step_r != '0);
        step_nxt    = step_r + cbq_pkg::STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd  = 1'b1;
        step_nxt = '0;
        if (!sec_r && sts.two_stage) begin
          sec_nxt   = 1'b1;
          state_nxt = ST_MAC;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      sec_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sec_r       <= sec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MAC |-> step_r <= STEP_LAST)
    else $error("tap step out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten before transaction");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_MAC && step_r == '0 && !sec_r))
    else $error("section one not started after accept");

  a_second_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && sec_r) |-> sts.two_stage)
    else $error("second section ran in single-stage mode");

endmodule

// File: design/cascaded_biquad_lp_hp_filter.sv
// Cascaded biquad low-pass / high-pass filter, top level.
// Depends on cbq_pkg, cbq_ctrl and cbq_datapath.
//
// One sample per transaction passes through one or two direct-form-I biquad
// sections sharing b0 (also b2), b1, a1, a2 in signed Q3.21; the result is the
// low-pass value or input minus it. One 24x32 multiplier does all products:
// each section runs its multiply-accumulate steps and then one history
// update, after the sample is accepted and before the output register is
// loaded. A finished result waits in the output register while the next
// sample is accepted. Configuration writes are always ready and must only
// be issued while the filter is idle.
module cascaded_biquad_lp_hp_filter #(
  parameter int SAMPLE_WIDTH   = cbq_pkg::SAMPLE_W_DEF,
  parameter int COEF_FRAC_BITS = cbq_pkg::COEF_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_sample_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]    out_sample_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  cbq_pkg::cbq_cmd_t cmd;
  cbq_pkg::cbq_sts_t sts;

  assign cfg_ready = 1'b1;

  cbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbq_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (in_sample_in),
    .cmd        (cmd),
    .sts        (sts),
    .sample_out (out_sample_out)
  );

endmodule

// File: tb/tb_top.sv
// Testbench for cascaded_biquad_lp_hp_filter: directed and random samples over
// many coefficient and mode settings, checked against a fixed-point predictor.
// Depends on cbq_pkg and the filter RTL.
module tb_top;

  localparam int SW              = cbq_pkg::SAMPLE_W_DEF;
  localparam int FRAC            = cbq_pkg::COEF_FRAC_DEF;
  localparam int CW              = cbq_pkg::COEF_W;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int RANDOM_PHASES   = 16;
  localparam int ITEMS_PER_PHASE = 106;
  localparam int DRAIN_CYCLES    = 40;
  localparam int PRINT_CAP       = 40;

  localparam logic [cbq_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [cbq_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic [cbq_pkg::STAGES_W-1:0] STAGES_NONE  = 2'd0;
  localparam logic [cbq_pkg::STAGES_W-1:0] STAGES_ONE   = 2'd1;
  localparam logic [cbq_pkg::STAGES_W-1:0] STAGES_THREE = 2'd3;

  localparam logic signed [SW-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SW-1:0] S_MIN = 24'sh800000;
  localparam logic signed [CW-1:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [CW-1:0] C_MIN = 24'sh800000;

  // 2nd-order Butterworth low-pass, fs 48 kHz, fc 2 kHz, Q3.21
  localparam logic signed [CW-1:0] LP_B0 = 24'sd30199;
  localparam logic signed [CW-1:0] LP_B1 = 24'sd60398;
  localparam logic signed [CW-1:0] LP_A1 = -24'sd3424698;
  localparam logic signed [CW-1:0] LP_A2 = 24'sd1448278;

  logic                               clk          = 1'b0;
  logic                               rst_n        = 1'b0;
  logic                               in_valid     = 1'b0;
  logic signed [SW-1:0]               in_sample_in = '0;
  logic                               out_stall    = 1'b0;
  logic                               cfg_valid    = 1'b0;
  logic [cbq_pkg::CFG_IDX_W-1:0]      cfg_index    = '0;
  logic [cbq_pkg::CFG_DATA_W-1:0]     cfg_data     = '0;
  logic                               in_stall;
  logic                               out_valid;
  logic signed [SW-1:0]               out_sample_out;
  logic                               cfg_ready;

  cascaded_biquad_lp_hp_filter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // shadow configuration and filter history
  logic signed [CW-1:0]               cf_b0 = '0;
  logic signed [CW-1:0]               cf_b1 = '0;
  logic signed [CW-1:0]               cf_a1 = '0;
  logic signed [CW-1:0]               cf_a2 = '0;
  logic [cbq_pkg::STAGES_W-1:0]       stage_sel = STAGES_ONE;
  logic                               hp_sel = 1'b0;
  logic signed [SW-1:0]               s1_x1 = '0, s1_x2 = '0;
  logic signed [cbq_pkg::STATE_W-1:0] s1_y1 = '0, s1_y2 = '0;
  logic signed [cbq_pkg::STATE_W-1:0] s2_x1 = '0, s2_x2 = '0;
  logic signed [cbq_pkg::STATE_W-1:0] s2_y1 = '0, s2_y2 = '0;

  logic signed [SW-1:0] pending_samples[$];
  logic signed [SW-1:0] expected_samples[$];
  logic signed [SW-1:0] last_sample = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int samples_sent   = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int settings_count = 0;
  int cycle_count    = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic logic signed [cbq_pkg::STATE_W-1:0] biquad_section(
    input longint x, input longint x1, input longint x2,
    input longint y1, input longint y2);
    longint b0, b1, a1, a2, acc;
    b0 = cf_b0;
    b1 = cf_b1;
    a1 = cf_a1;
    a2 = cf_a2;
    acc = ((b0 * x) >>> FRAC) + ((b1 * x1) >>> FRAC) + ((b0 * x2) >>> FRAC)
        - ((a1 * y1) >>> FRAC) - ((a2 * y2) >>> FRAC);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[cbq_pkg::STATE_W-1:0];
  endfunction

  function automatic logic signed [SW-1:0] filter_sample(input logic signed [SW-1:0] x);
    logic signed [cbq_pkg::STATE_W-1:0] y1, y2;
    longint lp, res;
    y1 = biquad_section(x, s1_x1, s1_x2, s1_y1, s1_y2);
    s1_x2 = s1_x1;
    s1_x1 = x;
    s1_y2 = s1_y1;
    s1_y1 = y1;
    lp = y1;
    if (stage_sel == cbq_pkg::STAGES_TWO) begin
      y2 = biquad_section(y1, s2_x1, s2_x2, s2_y1, s2_y2);
      s2_x2 = s2_x1;
      s2_x1 = y1;
      s2_y2 = s2_y1;
      s2_y1 = y2;
      lp = y2;
    end
    res = hp_sel ? longint'(x) - lp : lp;
    if (res > longint'(S_MAX)) res = S_MAX;
    if (res < longint'(S_MIN)) res = S_MIN;
    return res[SW-1:0];
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_samples.push_back(filter_sample(in_sample_in));
        samples_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid     <= 1'b1;
          in_sample_in <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    logic signed [SW-1:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("result %0d with no sample outstanding", out_sample_out));
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_out !== want)
            report_mismatch($sformatf("sample_out got %0d want %0d", out_sample_out, want));
          results_checked++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [cbq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cbq_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cbq_pkg::REG_B0:     cf_b0 = data[CW-1:0];
      cbq_pkg::REG_B1:     cf_b1 = data[CW-1:0];
      cbq_pkg::REG_A1:     cf_a1 = data[CW-1:0];
      cbq_pkg::REG_A2:     cf_a2 = data[CW-1:0];
      cbq_pkg::REG_STAGES: stage_sel = data[cbq_pkg::STAGES_W-1:0];
      cbq_pkg::REG_HP:     hp_sel = data[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // upper bits of the mode registers carry noise; they must be ignored
  task automatic apply_setting(
    input logic signed [CW-1:0] b0, input logic signed [CW-1:0] b1,
    input logic signed [CW-1:0] a1, input logic signed [CW-1:0] a2,
    input logic [cbq_pkg::STAGES_W-1:0] stg, input logic hp);
    logic [cbq_pkg::CFG_DATA_W-1:0] d;
    write_reg(cbq_pkg::REG_B0, b0);
    write_reg(cbq_pkg::REG_B1, b1);
    write_reg(cbq_pkg::REG_A1, a1);
    write_reg(cbq_pkg::REG_A2, a2);
    d = cbq_pkg::CFG_DATA_W'($urandom);
    d[cbq_pkg::STAGES_W-1:0] = stg;
    write_reg(cbq_pkg::REG_STAGES, d);
    d = cbq_pkg::CFG_DATA_W'($urandom);
    d[0] = hp;
    write_reg(cbq_pkg::REG_HP, d);
    if ($urandom_range(0, 3) == 0) write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                                             cbq_pkg::CFG_DATA_W'($urandom));
    settings_count++;
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || expected_samples.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coef();
    int k;
    int v;
    k = $urandom_range(0, 3);
    case (k)
      0: v = $urandom;
      1: begin
        v = $urandom_range(0, 2);
        v = (v == 0) ? C_MAX : (v == 1) ? C_MIN : 0;
      end
      2: v = $urandom_range(0, 4194304) - 2097152;
      default: v = $urandom_range(0, 8191) - 4096;
    endcase
    return v[CW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    int k;
    int v;
    k = $urandom_range(0, 9);
    if (k <= 5) v = $urandom;
    else if (k <= 7) v = $urandom_range(0, 8191) - 4096;
    else if (k == 8) v = $urandom_range(0, 1) ? S_MAX : S_MIN;
    else v = last_sample;
    last_sample = v[SW-1:0];
    return v[SW-1:0];
  endfunction

  initial begin
    int p, i, r;
    logic [cbq_pkg::STAGES_W-1:0] stg;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset coefficients: everything filters to zero
    pending_samples = '{S_MAX, S_MIN, 24'sd0, -24'sd1, 24'sd1};
    wait_idle();

    // extreme coefficients, two stages, high-pass: saturation everywhere
    apply_setting(C_MAX, C_MAX, C_MIN, C_MIN, cbq_pkg::STAGES_TWO, 1'b1);
    pending_samples = '{S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN};
    wait_idle();

    // opposite extremes, unused stage code three behaves as one stage
    apply_setting(C_MIN, C_MIN, C_MAX, C_MAX, STAGES_THREE, 1'b0);
    write_reg(REG_SPARE_B, 24'hFFFFFF);
    pending_samples = '{S_MAX, S_MIN, 24'sd0, S_MAX, S_MIN};
    wait_idle();

    // real low-pass, stage code zero keeps stage-2 history frozen
    apply_setting(LP_B0, LP_B1, LP_A1, LP_A2, STAGES_NONE, 1'b1);
    pending_samples = '{S_MAX, S_MAX, S_MIN, 24'sd1000};
    wait_idle();
    apply_setting(LP_B0, LP_B1, LP_A1, LP_A2, cbq_pkg::STAGES_TWO, 1'b0);
    pending_samples = '{S_MAX, S_MAX, S_MIN, -24'sd1000};
    wait_idle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      r = $urandom_range(0, 9);
      stg = (r == 0) ? STAGES_NONE : (r == 1) ? STAGES_THREE :
            (r <= 5) ? STAGES_ONE : cbq_pkg::STAGES_TWO;
      if ($urandom_range(0, 1))
        apply_setting(LP_B0, LP_B1, LP_A1, LP_A2, stg, 1'($urandom_range(0, 1)));
      else
        apply_setting(rand_coef(), rand_coef(), rand_coef(), rand_coef(), stg,
                      1'($urandom_range(0, 1)));
      for (i = 0; i < ITEMS_PER_PHASE; i++) pending_samples.push_back(rand_sample());
      wait_idle();
    end

    $display("summary: %0d samples filtered under %0d register settings, %0d results checked",
             samples_sent, settings_count, results_checked);
    $display("summary: %0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
